>>> design/cctc_pkg.sv
// Shared types and constants of the clock cycle time converter.
`default_nettype none

package cctc_pkg;

	localparam int unsigned AMOUNT_W = 64;
	localparam int unsigned OSC_W    = 32;
	localparam int unsigned CLK_W    = 8;
	localparam int unsigned RATE_W   = 32;
	localparam int unsigned MULT_W   = 32;
	localparam int unsigned PROD_W   = AMOUNT_W + MULT_W;
	localparam int unsigned CFG_IDX_W = 1;

	// Action codes carried in the input tuser field. Code 7 is unused.
	typedef enum logic [2:0] {
		ACT_STEP   = 3'd0,
		ACT_CLEAR  = 3'd1,
		ACT_CYC_NS = 3'd2,
		ACT_CYC_US = 3'd3,
		ACT_NS_CYC = 3'd4,
		ACT_US_CYC = 3'd5,
		ACT_RATE   = 3'd6
	} action_t;

	localparam logic [CFG_IDX_W-1:0] REG_OSC_FREQ = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_CLK_DIV  = 1'b1;

	localparam logic [OSC_W-1:0]  OSC_RESET  = 32'd12000000;
	localparam logic [CLK_W-1:0]  CLK_RESET  = 8'd12;
	localparam logic [MULT_W-1:0] NS_PER_SEC = 32'd1000000000;
	localparam logic [MULT_W-1:0] US_PER_SEC = 32'd1000000;

endpackage

`default_nettype wire

>>> design/clock_cycle_time_converter_unit.sv
// Top level: machine cycle / wall time converter with a serial mul-div datapath.
//
//  channel   dir  handshake         payload
//  s_*       in   tvalid/tready     tuser[2:0] action, tdata[63:0] amount
//  m_*       out  tvalid/tready     tdata[63:0] value, tuser[0] rate_is_zero
//  cfg_*     in   cfg_we            cfg_index, cfg_wdata[31:0]
//
// One transaction is in flight at a time. Step, clear and unused codes go straight to the output load.
// Read rate is a 32-step serial divide of osc by clocks per cycle.
// Conversions run the 32-step rate divide, the 32-step serial multiply and a
// 96-step serial divide of the product, plus state hand-offs and output load.
// A conversion that finds a zero rate ends after the rate divide.
// Output stall holds the result register; a new input is taken once it is loaded.
// Reset is asynchronous and restores the register defaults and a zero total.
`default_nettype none

module clock_cycle_time_converter_unit
	import cctc_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	// input stream
	input  wire logic                 s_tvalid,
	output logic                      s_tready,
	input  wire logic [63:0]          s_tdata,   // [63:0] amount
	input  wire logic [2:0]           s_tuser,   // [2:0] action
	// output stream
	output logic                      m_tvalid,
	input  wire logic                 m_tready,
	output logic [63:0]               m_tdata,   // [63:0] value
	output logic [0:0]                m_tuser,   // [0] rate_is_zero
	// configuration
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [OSC_W-1:0]     cfg_wdata
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RATE,
		ST_MUL,
		ST_DIV,
		ST_OUT
	} state_t;

	state_t               state_q;
	logic [2:0]           act_q;
	logic [AMOUNT_W-1:0]  amt_q;
	logic [AMOUNT_W-1:0]  res_q;
	logic                 flag_q;
	logic [AMOUNT_W-1:0]  total_q;
	logic                 m_tvalid_q;
	logic [AMOUNT_W-1:0]  m_tdata_q;
	logic                 m_tuser_q;
	logic [OSC_W-1:0]     osc_q;
	logic [CLK_W-1:0]     clkdiv_q;

	logic                 in_fire;
	logic [AMOUNT_W-1:0]  step_sum;

	logic                 rate_start;
	logic                 rate_busy;
	logic                 rate_done;
	logic [RATE_W-1:0]    rate_quo;
	logic                 rate_zero;

	logic                 mul_start;
	logic                 mul_busy;
	logic                 mul_done;
	logic [MULT_W-1:0]    mul_y;
	logic [PROD_W-1:0]    mul_prod;

	logic                 div_start;
	logic                 div_busy;
	logic                 div_done;
	logic [MULT_W-1:0]    div_dvs;
	logic [AMOUNT_W-1:0]  div_quo;

	logic                 needs_rate;

	assign s_tready = (state_q == ST_IDLE);
	assign in_fire  = s_tvalid && s_tready;
	assign step_sum = total_q + {32'd0, s_tdata[31:0]};
	assign rate_zero = (rate_quo == '0);

	always_comb begin
		case (s_tuser)
			ACT_CYC_NS, ACT_CYC_US, ACT_NS_CYC, ACT_US_CYC, ACT_RATE: needs_rate = 1'b1;
			default: needs_rate = 1'b0;
		endcase
	end

	// operand selection per conversion
	always_comb begin
		case (act_q)
			ACT_CYC_NS: begin
				mul_y   = NS_PER_SEC;
				div_dvs = rate_quo;
			end
			ACT_CYC_US: begin
				mul_y   = US_PER_SEC;
				div_dvs = rate_quo;
			end
			ACT_NS_CYC: begin
				mul_y   = rate_quo;
				div_dvs = NS_PER_SEC;
			end
			default: begin
				mul_y   = rate_quo;
				div_dvs = US_PER_SEC;
			end
		endcase
	end

	assign rate_start = in_fire && needs_rate;
	assign mul_start  = (state_q == ST_RATE) && rate_done && (act_q != ACT_RATE) && !rate_zero;
	assign div_start  = (state_q == ST_MUL) && mul_done;

	cctc_serdiv #(
		.DVD_W (OSC_W),
		.DVS_W (CLK_W),
		.QUO_W (RATE_W)
	) u_rate_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (rate_start),
		.dividend (osc_q),
		.divisor  (clkdiv_q),
		.busy     (rate_busy),
		.done     (rate_done),
		.quotient (rate_quo)
	);

	cctc_sermul #(
		.X_W (AMOUNT_W),
		.Y_W (MULT_W)
	) u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mul_start),
		.x       (amt_q),
		.y       (mul_y),
		.busy    (mul_busy),
		.done    (mul_done),
		.product (mul_prod)
	);

	cctc_serdiv #(
		.DVD_W (PROD_W),
		.DVS_W (MULT_W),
		.QUO_W (AMOUNT_W)
	) u_main_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (mul_prod),
		.divisor  (div_dvs),
		.busy     (div_busy),
		.done     (div_done),
		.quotient (div_quo)
	);

	// configuration registers; a zero clock divider is ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			osc_q    <= OSC_RESET;
			clkdiv_q <= CLK_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_OSC_FREQ: osc_q <= cfg_wdata;
				REG_CLK_DIV: begin
					if (cfg_wdata[CLK_W-1:0] != '0) begin
						clkdiv_q <= cfg_wdata[CLK_W-1:0];
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			act_q      <= '0;
			amt_q      <= '0;
			res_q      <= '0;
			flag_q     <= 1'b0;
			total_q    <= '0;
			m_tvalid_q <= 1'b0;
			m_tdata_q  <= '0;
			m_tuser_q  <= 1'b0;
		end else begin
			// the load in ST_OUT handles the output register itself
			if (m_tready && state_q != ST_OUT) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						act_q  <= s_tuser;
						amt_q  <= s_tdata;
						flag_q <= 1'b0;
						case (s_tuser)
							ACT_STEP: begin
								total_q <= step_sum;
								res_q   <= step_sum;
								state_q <= ST_OUT;
							end
							ACT_CLEAR: begin
								total_q <= '0;
								res_q   <= '0;
								state_q <= ST_OUT;
							end
							ACT_CYC_NS, ACT_CYC_US, ACT_NS_CYC, ACT_US_CYC, ACT_RATE: begin
								state_q <= ST_RATE;
							end
							default: begin
								res_q   <= '0;
								state_q <= ST_OUT;
							end
						endcase
					end
				end
				ST_RATE: begin
					if (rate_done) begin
						if (act_q == ACT_RATE) begin
							res_q   <= {32'd0, rate_quo};
							state_q <= ST_OUT;
						end else if (rate_zero) begin
							res_q   <= '0;
							flag_q  <= 1'b1;
							state_q <= ST_OUT;
						end else begin
							state_q <= ST_MUL;
						end
					end
				end
				ST_MUL: begin
					if (mul_done) begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (div_done) begin
						res_q   <= div_quo;
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q <= 1'b1;
						m_tdata_q  <= res_q;
						m_tuser_q  <= flag_q;
						state_q    <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_tvalid   = m_tvalid_q;
	assign m_tdata    = m_tdata_q;
	assign m_tuser[0] = m_tuser_q;

	// a zero-rate flag always comes with a zero value
	a_flag_zero_value: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> m_tdata == '0)
		else $error("rate_is_zero set with nonzero value");

	// no arithmetic unit may still run when a new transaction can be taken
	a_idle_engines: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !rate_busy && !mul_busy && !div_busy)
		else $error("engine busy while accepting input");

	// results appear only through the output load state
	a_out_from_load: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(state_q == ST_OUT))
		else $error("output valid raised outside output load");

endmodule

`default_nettype wire

>>> design/cctc_serdiv.sv
// Bit-serial restoring divider, one quotient bit per cycle.
`default_nettype none

module cctc_serdiv #(
	parameter int unsigned DVD_W = 32,
	parameter int unsigned DVS_W = 8,
	parameter int unsigned QUO_W = 32
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [DVD_W-1:0] dividend,
	input  wire logic [DVS_W-1:0] divisor,   // held stable while busy
	output logic                  busy,
	output logic                  done,
	output logic [QUO_W-1:0]      quotient
);

	localparam int unsigned CNT_W = $clog2(DVD_W + 1);

	logic [DVD_W-1:0] dvd_q;
	logic [DVS_W-1:0] rem_q;
	logic [QUO_W-1:0] quo_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;

	logic [DVS_W:0] trial;
	logic [DVS_W:0] diff;
	logic           fits;

	always_comb begin
		trial = {rem_q, dvd_q[DVD_W-1]};
		diff  = trial - {1'b0, divisor};
		fits  = (trial >= {1'b0, divisor});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dvd_q  <= '0;
			rem_q  <= '0;
			quo_q  <= '0;
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				dvd_q  <= dividend;
				rem_q  <= '0;
				quo_q  <= '0;
				cnt_q  <= CNT_W'(DVD_W);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				rem_q <= fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
				// upper quotient bits fall off: result is taken modulo 2^QUO_W
				quo_q <= {quo_q[QUO_W-2:0], fits};
				dvd_q <= {dvd_q[DVD_W-2:0], 1'b0};
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign busy     = busy_q;
	assign done     = done_q;
	assign quotient = quo_q;

endmodule

`default_nettype wire

>>> design/cctc_sermul.sv
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
`default_nettype none

module cctc_sermul #(
	parameter int unsigned X_W = 64,
	parameter int unsigned Y_W = 32
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           start,
	input  wire logic [X_W-1:0] x,        // held stable while busy
	input  wire logic [Y_W-1:0] y,
	output logic                busy,
	output logic                done,
	output logic [X_W+Y_W-1:0]  product
);

	localparam int unsigned CNT_W = $clog2(Y_W + 1);

	logic [X_W+Y_W-1:0] prod_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               busy_q;
	logic               done_q;
	logic [X_W:0]       sum;

	// low part holds the remaining multiplier bits, LSB first
	assign sum = {1'b0, prod_q[X_W+Y_W-1:Y_W]} + (prod_q[0] ? {1'b0, x} : '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prod_q <= '0;
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				prod_q <= {{X_W{1'b0}}, y};
				cnt_q  <= CNT_W'(Y_W);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				prod_q <= {sum, prod_q[Y_W-1:1]};
				cnt_q  <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign busy    = busy_q;
	assign done    = done_q;
	assign product = prod_q;

endmodule

`default_nettype wire

>>> bench/cctc_checker.sv
// Checker for the cycle/time converter: watches all channels, predicts each result and compares.
`default_nettype none

module cctc_checker
	import cctc_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 s_tvalid,
	input  wire logic                 s_tready,
	input  wire logic [63:0]          s_tdata,
	input  wire logic [2:0]           s_tuser,
	input  wire logic                 m_tvalid,
	input  wire logic                 m_tready,
	input  wire logic [63:0]          m_tdata,
	input  wire logic [0:0]           m_tuser,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [OSC_W-1:0]     cfg_wdata,
	output int                        mismatches,
	output int                        outstanding,
	output int                        results_seen,
	output int                        zero_rate_seen
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [2:0]  act;
		logic [63:0] amount;
		logic [63:0] value;
		logic        rate_zero;
	} answer_t;

	logic [OSC_W-1:0] osc_hz;
	logic [CLK_W-1:0] clk_div;
	logic [63:0]      running_total;
	answer_t          answers_due[$];
	answer_t          due;
	int               bad_count;
	int               seen_count;
	int               flagged_count;

	// floor(x * mul / div), low 64 bits of the quotient
	function automatic logic [63:0] scale(input logic [63:0] x, input logic [63:0] mul,
			input logic [63:0] div);
		logic [127:0] prod;
		logic [127:0] quot;
		prod = {64'd0, x} * {64'd0, mul};
		quot = prod / {64'd0, div};
		return quot[63:0];
	endfunction

	function automatic answer_t predict_answer(input logic [2:0] act, input logic [63:0] amount);
		answer_t     a;
		logic [63:0] cps;
		cps = {32'd0, osc_hz} / {56'd0, clk_div};
		a.act       = act;
		a.amount    = amount;
		a.value     = '0;
		a.rate_zero = 1'b0;
		case (action_t'(act))
			ACT_STEP: begin
				running_total = running_total + {32'd0, amount[31:0]};
				a.value = running_total;
			end
			ACT_CLEAR: begin
				running_total = '0;
			end
			ACT_CYC_NS, ACT_CYC_US, ACT_NS_CYC, ACT_US_CYC: begin
				if (cps == 0) begin
					a.rate_zero = 1'b1;
				end else begin
					case (action_t'(act))
						ACT_CYC_NS: a.value = scale(amount, {32'd0, NS_PER_SEC}, cps);
						ACT_CYC_US: a.value = scale(amount, {32'd0, US_PER_SEC}, cps);
						ACT_NS_CYC: a.value = scale(amount, cps, {32'd0, NS_PER_SEC});
						default:    a.value = scale(amount, cps, {32'd0, US_PER_SEC});
					endcase
				end
			end
			ACT_RATE: begin
				a.value = cps;
			end
			default: begin
				// unused code: no effect, zero result
			end
		endcase
		return a;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			osc_hz         = OSC_RESET;
			clk_div        = CLK_RESET;
			running_total  = '0;
			answers_due.delete();
			bad_count      = 0;
			seen_count     = 0;
			flagged_count  = 0;
			mismatches     <= 0;
			outstanding    <= 0;
			results_seen   <= 0;
			zero_rate_seen <= 0;
		end else begin
			// results first: one transaction in flight, so an output never belongs to
			// an input accepted on the same edge
			if (m_tvalid && m_tready) begin
				seen_count++;
				if (m_tuser[0])
					flagged_count++;
				if (answers_due.size() == 0) begin
					if (bad_count < 10)
						$display("ERROR: unexpected result value %h rate_is_zero %b",
							m_tdata, m_tuser[0]);
					bad_count++;
				end else begin
					due = answers_due.pop_front();
					if (m_tdata !== due.value || m_tuser[0] !== due.rate_zero) begin
						if (bad_count < 10)
							$display("ERROR: act %0d amt %h: exp %h/%b got %h/%b",
								due.act, due.amount, due.value, due.rate_zero,
								m_tdata, m_tuser[0]);
						bad_count++;
					end
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					REG_OSC_FREQ: osc_hz = cfg_wdata;
					REG_CLK_DIV: begin
						if (cfg_wdata[CLK_W-1:0] != 0)
							clk_div = cfg_wdata[CLK_W-1:0];
					end
					default: ;
				endcase
			end
			if (s_tvalid && s_tready)
				answers_due.push_back(predict_answer(s_tuser, s_tdata));
			mismatches     <= bad_count;
			outstanding    <= answers_due.size();
			results_seen   <= seen_count;
			zero_rate_seen <= flagged_count;
		end
	end

endmodule

`default_nettype wire

>>> bench/tb_top.sv
// Testbench top: clock, reset, stimulus, register settings and verdict for the converter.
`default_nettype none

module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import cctc_pkg::*;

	localparam logic [2:0] ACT_UNUSED = 3'd7;
	localparam int         PHASES     = 9;
	localparam int         PHASE_LEN  = 150;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 s_tvalid  = 1'b0;
	logic [63:0]          s_tdata   = '0;
	logic [2:0]           s_tuser   = '0;
	logic                 m_tready  = 1'b0;
	logic                 cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [OSC_W-1:0]     cfg_wdata = '0;
	wire logic            s_tready;
	wire logic            m_tvalid;
	wire logic [63:0]     m_tdata;
	wire logic [0:0]      m_tuser;

	int mismatches;
	int outstanding;
	int results_seen;
	int zero_rate_seen;
	bit no_idle = 1'b0;
	int items_sent = 0;
	int settings_used = 0;

	clock_cycle_time_converter_unit u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	cctc_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.s_tvalid       (s_tvalid),
		.s_tready       (s_tready),
		.s_tdata        (s_tdata),
		.s_tuser        (s_tuser),
		.m_tvalid       (m_tvalid),
		.m_tready       (m_tready),
		.m_tdata        (m_tdata),
		.m_tuser        (m_tuser),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_wdata      (cfg_wdata),
		.mismatches     (mismatches),
		.outstanding    (outstanding),
		.results_seen   (results_seen),
		.zero_rate_seen (zero_rate_seen)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// watchdog: a run that has not finished by this time is reported as a mismatch
	initial begin
		#25_000_000;
		$display("clock_cycle_time_converter_unit: mismatch");
		$finish;
	end

	task automatic send(input logic [2:0] act, input logic [63:0] amount);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 12);
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= act;
		s_tdata  <= amount;
		do @(posedge clk); while (!(s_tvalid && s_tready));
		items_sent++;
	endtask

	// stop sending and let every predicted result drain
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_regs(input logic [OSC_W-1:0] osc, input logic [OSC_W-1:0] clk_word);
		wait_idle();
		cfg_we    <= 1'b1;
		cfg_index <= REG_OSC_FREQ;
		cfg_wdata <= osc;
		@(posedge clk);
		cfg_index <= REG_CLK_DIV;
		cfg_wdata <= clk_word;
		@(posedge clk);
		cfg_we <= 1'b0;
		settings_used++;
	endtask

	function automatic logic [OSC_W-1:0] pick_osc();
		case ($urandom_range(0, 5))
			0:       return '0;
			1:       return '1;
			2:       return OSC_RESET;
			3:       return OSC_W'($urandom_range(0, 300));
			default: return $urandom;
		endcase
	endfunction

	// upper bits are don't-care; a zero low byte is an ignored write
	function automatic logic [OSC_W-1:0] pick_clk_word();
		case ($urandom_range(0, 4))
			0:       return 32'd1;
			1:       return 32'd255;
			2:       return {24'($urandom_range(0, 32'h00FF_FFFF)), 8'd0};
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [63:0] pick_amount();
		case ($urandom_range(0, 5))
			0:       return '0;
			1:       return '1;
			2:       return {$urandom, $urandom};
			3:       return {32'd0, $urandom};
			4:       return 64'($urandom_range(0, 1000));
			default: return {$urandom_range(0, 255), $urandom};
		endcase
	endfunction

	// sink: random stall before each result, none while no_idle is set
	initial begin
		int stall;
		@(posedge arst_n);
		forever begin
			stall = no_idle ? 0 : $urandom_range(0, 12);
			if (stall != 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!(m_tvalid && m_tready));
		end
	end

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset register values
		send(ACT_STEP, 64'd0);
		send(ACT_STEP, '1);
		send(ACT_STEP, 64'h0123_4567_89AB_CDEF);
		send(ACT_RATE, 64'd0);
		send(ACT_CYC_NS, '1);
		send(ACT_CYC_US, 64'd1);
		send(ACT_NS_CYC, '1);
		send(ACT_US_CYC, 64'd0);
		send(ACT_UNUSED, '1);
		send(ACT_CLEAR, '1);
		send(ACT_STEP, 64'd5);

		// zero oscillator; clocks write of zero must leave the divider alone
		set_regs('0, '0);
		send(ACT_CYC_NS, 64'd1000);
		send(ACT_CYC_US, '1);
		send(ACT_NS_CYC, 64'd1000);
		send(ACT_US_CYC, '1);
		send(ACT_RATE, 64'd0);

		// largest rate; the time-to-cycles quotients overflow 64 bits
		set_regs('1, 32'd1);
		send(ACT_CYC_NS, '1);
		send(ACT_CYC_US, '1);
		send(ACT_NS_CYC, '1);
		send(ACT_US_CYC, '1);
		send(ACT_RATE, 64'd0);

		// oscillator just below the divider gives zero rate
		set_regs(32'd254, 32'd255);
		set_regs(32'd254, 32'hFFFF_FF00);
		send(ACT_CYC_NS, 64'd7);
		send(ACT_RATE, 64'd0);

		for (int ph = 0; ph < PHASES; ph++) begin
			if (ph == 0)
				set_regs(OSC_RESET, {24'd0, CLK_RESET});
			else
				set_regs(pick_osc(), pick_clk_word());
			no_idle = (ph % 4 == 3);
			for (int i = 0; i < PHASE_LEN; i++)
				send(3'($urandom_range(0, 7)), pick_amount());
		end
		no_idle = 1'b0;

		wait_idle();
		repeat (20) @(posedge clk);
		$display("Run covered %0d input transactions under %0d register settings.",
			items_sent, settings_used);
		$display("%0d results compared, %0d of them flagged a zero rate.",
			results_seen, zero_rate_seen);
		if (mismatches == 0) begin
			$display("clock_cycle_time_converter_unit: match");
		end else begin
			$display("clock_cycle_time_converter_unit: mismatch");
		end
		$finish;
	end

endmodule

`default_nettype wire
